/* rtl/cdsq_pkg.sv */
// ----------------------------------------------------------------------------
// cdsq_pkg
// Shared types and the byte-wide CRC-16 update for the Q-subchannel framer.
// ----------------------------------------------------------------------------
package cdsq_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'h0000;

	// Position of the word being shown within the results of one input word.
	typedef enum logic [1:0] {
		PH_ECHO,
		PH_HIGH,
		PH_LOW
	} phase_t;

	// A staged input word together with the inverted CRC of its frame.
	typedef struct packed {
		logic        valid;
		logic [7:0]  data;
		logic        frame_end;
		logic [15:0] check;
	} stage_t;

	// CRC-16, polynomial 0x1021, MSB first, one byte folded in.
	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

/* rtl/cdsq_if.sv */
// ----------------------------------------------------------------------------
// cdsq_in_if / cdsq_out_if
// Valid/ready channels carrying payload words in and framed words out.
// ----------------------------------------------------------------------------
interface cdsq_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface cdsq_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_check;
	logic       frame_last;

	modport source (output valid, output out_byte, output is_check, output frame_last,
		input ready);
	modport sink   (input valid, input out_byte, input is_check, input frame_last,
		output ready);
endinterface

/* rtl/cdsq_emit.sv */
// ----------------------------------------------------------------------------
// cdsq_emit
// Result register and serializer: shows the echoed word and, at the end of a
// frame, the two inverted CRC bytes.
// ----------------------------------------------------------------------------
module cdsq_emit
	import cdsq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t load,
	output logic   load_ready,
	cdsq_out_if.source dout
);

	logic   valid_s1;
	stage_t word_s1;
	phase_t ph_q;
	phase_t ph_d;
	logic   last_phase;
	logic   fire;

	assign last_phase = (ph_q == PH_LOW) || (ph_q == PH_ECHO && !word_s1.frame_end);
	assign fire       = dout.valid && dout.ready;
	assign load_ready = !valid_s1 || (dout.ready && last_phase);

	always_comb begin
		ph_d = ph_q;
		unique case (ph_q)
			PH_ECHO: if (fire && word_s1.frame_end) ph_d = PH_HIGH;
			PH_HIGH: if (fire) ph_d = PH_LOW;
			PH_LOW:  if (fire) ph_d = PH_ECHO;
			default: ph_d = PH_ECHO;
		endcase
		if (load.valid && load_ready) ph_d = PH_ECHO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ph_q     <= PH_ECHO;
		end else begin
			ph_q <= ph_d;
			if (load.valid && load_ready) begin
				valid_s1 <= 1'b1;
			end else if (fire && last_phase) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load.valid && load_ready) begin
			word_s1 <= load;
		end
	end

	always_comb begin
		dout.valid = valid_s1;
		unique case (ph_q)
			PH_ECHO: begin
				dout.out_byte   = word_s1.data;
				dout.is_check   = 1'b0;
				dout.frame_last = 1'b0;
			end
			PH_HIGH: begin
				dout.out_byte   = word_s1.check[15:8];
				dout.is_check   = 1'b1;
				dout.frame_last = 1'b0;
			end
			PH_LOW: begin
				dout.out_byte   = word_s1.check[7:0];
				dout.is_check   = 1'b1;
				dout.frame_last = 1'b1;
			end
			default: begin
				dout.out_byte   = word_s1.data;
				dout.is_check   = 1'b0;
				dout.frame_last = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/cd_subq_crc_framer.sv */
// ----------------------------------------------------------------------------
// cd_subq_crc_framer
// Echoes Q-subchannel payload bytes and appends the inverted CRC-16 of each
// frame, high byte first, with the low byte flagged as the frame's last.
// ----------------------------------------------------------------------------
//  channel  dir  fields                          accepted when
//  din      in   data_byte[7:0], frame_end       din.valid && din.ready
//  dout     out  out_byte[7:0], is_check,        dout.valid && dout.ready
//                frame_last
//
// A payload word is accepted every cycle while the output side keeps up; a
// word with frame_end set occupies the result register for its echo and the
// two CRC bytes, so din waits until the frame's low CRC byte is taken.
// The CRC is updated in the accept cycle by a byte-wide XOR network.
// Reset clears the CRC to zero and empties the result register. A stalled
// output holds its word and blocks din only once the result register is full.
// ----------------------------------------------------------------------------
module cd_subq_crc_framer
	import cdsq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cdsq_in_if.sink    din,
	cdsq_out_if.source dout
);

	logic [15:0] crc_q;
	logic [15:0] crc_new;
	logic        load_ready;
	logic        accept;
	stage_t      load;

	assign crc_new   = crc_next(crc_q, din.data_byte);
	assign din.ready = load_ready;
	assign accept    = din.valid && load_ready;

	assign load.valid     = din.valid;
	assign load.data      = din.data_byte;
	assign load.frame_end = din.frame_end;
	assign load.check     = ~crc_new;

	// The accumulator starts over after the last byte of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (accept) begin
			crc_q <= din.frame_end ? CRC_INIT : crc_new;
		end
	end

	cdsq_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_ready (load_ready),
		.dout       (dout)
	);

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives Q-subchannel payload words into cd_subq_crc_framer, predicts the
// echoed bytes and the two inverted CRC-16 bytes of each frame, and checks
// every output word in order. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_check;
		logic       frame_last;
	} framed_word_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n;

	cdsq_in_if  din_if ();
	cdsq_out_if dout_if ();

	cd_subq_crc_framer dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if),
		.dout  (dout_if)
	);

	// Predictor state: the CRC of the frame in progress.
	logic [15:0]  crc_running = 16'h0000;
	framed_word_t expected_words[$];
	framed_word_t got_word;
	framed_word_t want_word;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int words_sent = 0;
	int words_seen = 0;
	int frames_closed = 0;
	int cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words still expected", $time,
				expected_words.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Bit-serial CRC-16 (0x1021), data bits fed in MSB first.
	function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc,
		input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
		end
		return c;
	endfunction

	task automatic predict_framed_words(input logic [7:0] b, input logic fe);
		logic [15:0] inv;
		expected_words.push_back('{out_byte: b, is_check: 1'b0, frame_last: 1'b0});
		crc_running = fold_crc_byte(crc_running, b);
		if (fe) begin
			inv = ~crc_running;
			expected_words.push_back('{out_byte: inv[15:8], is_check: 1'b1,
				frame_last: 1'b0});
			expected_words.push_back('{out_byte: inv[7:0], is_check: 1'b1,
				frame_last: 1'b1});
			crc_running = 16'h0000;
			frames_closed++;
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: word %0d %s mismatch: expected 0x%0h, actual 0x%0h",
				$time, words_seen, name, want, got);
			errors++;
		end
	endtask

	// Output monitor and receiver stall generator.
	always @(posedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready) begin
			got_word = '{out_byte: dout_if.out_byte, is_check: dout_if.is_check,
				frame_last: dout_if.frame_last};
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual 0x%0h", $time,
					got_word);
				errors++;
			end else begin
				want_word = expected_words.pop_front();
				compare_field("out_byte", int'(want_word.out_byte),
					int'(got_word.out_byte));
				compare_field("is_check", int'(want_word.is_check),
					int'(got_word.is_check));
				compare_field("frame_last", int'(want_word.frame_last),
					int'(got_word.frame_last));
			end
			words_seen++;
		end
		dout_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Called at a clock edge; returns at the edge where the word was taken.
	task automatic send_word(input logic [7:0] b, input logic fe);
		while ($urandom_range(99) < send_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.data_byte <= b;
		din_if.frame_end <= fe;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		predict_framed_words(b, fe);
		words_sent++;
	endtask

	task automatic test_one_byte_frames();
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_word(8'h80, 1'b1);
		send_word(8'h01, 1'b1);
	endtask

	task automatic test_standard_q_frame();
		logic [7:0] q_frame[10];
		q_frame = '{8'h41, 8'h01, 8'h01, 8'h00, 8'h02, 8'h10, 8'h00, 8'h00,
			8'h02, 8'h10};
		for (int i = 0; i < 10; i++)
			send_word(q_frame[i], i == 9);
	endtask

	task automatic test_extreme_bytes();
		for (int i = 0; i < 4; i++)
			send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'hAA, 1'b0);
		send_word(8'h55, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
	endtask

	// Mostly well-formed frames with random bytes; some runs with random
	// frame_end flags act as broken frames.
	task automatic test_random_frames(input int send_pct, input int recv_pct,
		input int n_words);
		int target;
		int len;
		int r;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		target = words_sent + n_words;
		while (words_sent < target) begin
			r = $urandom_range(99);
			if (r < 10) begin
				len = $urandom_range(8, 1);
				for (int i = 0; i < len; i++)
					send_word(8'($urandom_range(255)), $urandom_range(3) == 0);
			end else begin
				if (r < 60)
					len = 10;
				else if (r < 78)
					len = $urandom_range(3, 1);
				else if (r < 95)
					len = $urandom_range(16, 4);
				else
					len = $urandom_range(40, 17);
				for (int i = 0; i < len; i++)
					send_word(8'($urandom_range(255)), i == len - 1);
			end
		end
	endtask

	task automatic wait_for_drain();
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.data_byte = 8'h00;
		din_if.frame_end = 1'b0;
		dout_if.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_one_byte_frames();
		test_standard_q_frame();
		test_extreme_bytes();

		test_random_frames(0, 0, 100);
		test_random_frames(78, 0, 100);
		test_random_frames(0, 78, 100);
		test_random_frames(14, 14, 100);

		din_if.valid <= 1'b0;
		wait_for_drain();

		$display("Sent %0d payload words closing %0d frames; checked %0d output words.",
			words_sent, frames_closed, words_seen);
		$display("Phases: no idling, sender gaps, receiver stalls, both; %0d errors.",
			errors + expected_words.size());
		if (errors == 0 && expected_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/cdsq_pkg.sv
rtl/cdsq_if.sv
rtl/cdsq_emit.sv
rtl/cd_subq_crc_framer.sv
dv/testbench.sv
